// ----- rtl/core/tlf_pkg.sv -----
package tlf_pkg;

	localparam int SUM_W      = 256;
	localparam int CNT_W      = 8;
	localparam int MIN_FIT    = 4;
	localparam int MQS_W      = 5;
	localparam int RTT_W      = 20;
	localparam int RESET_MQS  = 20;
	localparam int RESET_RTT  = 20000;

	localparam logic REG_MAX_QUEUE = 1'b0;
	localparam logic REG_MAX_RTT   = 1'b1;

	typedef enum logic [2:0] {
		ST_FITTED  = 3'd0,
		ST_COLLECT = 3'd1,
		ST_REJECT  = 3'd2,
		ST_STOPPED = 3'd3,
		ST_DEGEN   = 3'd4,
		ST_CLEARED = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		MUL_XX,
		MUL_XY,
		MUL_N_SXX,
		MUL_SX_SX,
		MUL_N_SXY,
		MUL_SX_SY,
		MUL_SXX_SY,
		MUL_SXY_SX,
		MUL_SYS0_D,
		MUL_NA_DEV0
	} mul_op_t;

	typedef enum logic {
		DIV_SLOPE,
		DIV_ICPT
	} div_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_DROP,
		S_BACK,
		S_PUSH,
		S_WRD,
		S_WTAKE,
		S_MUL_GO,
		S_MUL_WAIT,
		S_CHKD,
		S_DIV_GO,
		S_DIV_WAIT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic     load;
		logic     clear_win;
		logic     drop;
		logic     back;
		logic     push;
		logic     rd_k;
		logic     take_k;
		logic     mul_start;
		mul_op_t  mul_op;
		logic     div_start;
		div_sel_t div_sel;
		logic     emit;
		status_t  code;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic rtt_over;
		logic fit_next;
		logic last_k;
		logic mul_done;
		logic div_done;
		logic d_bad;
		logic out_free;
	} stat_t;

endpackage

// ----- rtl/core/tlf_if.sv -----
interface tlf_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [63:0] sys_before;
	logic [63:0] sys_after;
	logic [63:0] dev_time;

	modport source (output valid, kind, sys_before, sys_after, dev_time, input ready);
	modport sink (input valid, kind, sys_before, sys_after, dev_time, output ready);
endinterface

interface tlf_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic signed [63:0] slope;
	logic signed [63:0] intercept;
	logic [63:0] check_dev;
	logic [63:0] check_sys;
	logic [5:0]  window_count;

	modport source (output valid, status, slope, intercept, check_dev, check_sys,
		window_count, input ready);
	modport sink (input valid, status, slope, intercept, check_dev, check_sys,
		window_count, output ready);
endinterface

// ----- rtl/core/tlf_mul.sv -----
module tlf_mul (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [tlf_pkg::SUM_W-1:0] a,
	input  logic [tlf_pkg::SUM_W-1:0] b,
	input  logic [2:0]               a_top,
	output logic [tlf_pkg::SUM_W-1:0] prod,
	output logic                     done
);

	// Product modulo 2^256, one 32x32 partial product per cycle. Only words of a up to
	// a_top take part; higher words of a must be zero.
	logic [tlf_pkg::SUM_W-1:0] a_q, b_q, acc_q;
	logic [2:0]  i_q, j_q, aw_q, off_s1;
	logic        busy_q, v_s1, last_s1, done_q;
	logic [63:0] p_s1;
	logic        last_j;

	assign last_j = (j_q == 3'd7 - i_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			v_s1   <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
			j_q    <= '0;
		end else begin
			done_q <= v_s1 && last_s1;
			v_s1   <= busy_q;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				j_q    <= '0;
			end else if (busy_q) begin
				if (last_j) begin
					j_q <= '0;
					if (i_q == aw_q) begin
						busy_q <= 1'b0;
					end else begin
						i_q <= i_q + 3'd1;
					end
				end else begin
					j_q <= j_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			aw_q  <= a_top;
			acc_q <= '0;
		end else if (v_s1) begin
			acc_q <= acc_q + ({192'b0, p_s1} << {off_s1, 5'b0});
		end
		p_s1    <= a_q[32*i_q +: 32] * b_q[32*j_q +: 32];
		off_s1  <= i_q + j_q;
		last_s1 <= last_j && (i_q == aw_q);
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

// ----- rtl/core/tlf_div.sv -----
module tlf_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [tlf_pkg::SUM_W-1:0] num,
	input  logic [tlf_pkg::SUM_W-1:0] den,
	output logic [63:0]              quo,
	output logic                     done
);

	// Restoring division, one quotient bit per cycle. The quotient truncates toward zero
	// and is saturated to the signed 64-bit range. den must be positive.
	logic [tlf_pkg::SUM_W-1:0] mag_q, den_q, r_q, q_q, r_sh, r_nx;
	logic [tlf_pkg::CNT_W-1:0] cnt_q;
	logic        busy_q, fin_q, done_q, neg_q, ge, high;
	logic [63:0] res_q, q64;

	assign r_sh = {r_q[tlf_pkg::SUM_W-2:0], mag_q[tlf_pkg::SUM_W-1]};
	assign ge   = (r_sh >= den_q);
	assign r_nx = ge ? r_sh - den_q : r_sh;
	assign high = |q_q[tlf_pkg::SUM_W-1:64];
	assign q64  = q_q[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[tlf_pkg::SUM_W-1];
			mag_q <= num[tlf_pkg::SUM_W-1] ? -num : num;
			den_q <= den;
			r_q   <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			r_q   <= r_nx;
			q_q   <= {q_q[tlf_pkg::SUM_W-2:0], ge};
			mag_q <= {mag_q[tlf_pkg::SUM_W-2:0], 1'b0};
		end
		if (fin_q) begin
			if (neg_q) begin
				if (high || (q64 > 64'h8000_0000_0000_0000)) begin
					res_q <= 64'h8000_0000_0000_0000;
				end else begin
					res_q <= -q64;
				end
			end else begin
				if (high || q64[63]) begin
					res_q <= 64'h7FFF_FFFF_FFFF_FFFF;
				end else begin
					res_q <= q64;
				end
			end
		end
	end

	assign quo  = res_q;
	assign done = done_q;

endmodule

// ----- rtl/core/tlf_dp.sv -----
module tlf_dp #(
	parameter int WINDOW_DEPTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tlf_pkg::cmd_t               cmd,
	output tlf_pkg::stat_t              st,
	input  logic [tlf_pkg::MQS_W-1:0]   max_queue_size,
	input  logic [tlf_pkg::RTT_W-1:0]   max_rtt,
	input  logic                        kind,
	input  logic [63:0]                 sys_before,
	input  logic [63:0]                 sys_after,
	input  logic [63:0]                 dev_time,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  status,
	output logic signed [63:0]          slope,
	output logic signed [63:0]          intercept,
	output logic [63:0]                 check_dev,
	output logic [63:0]                 check_sys,
	output logic [5:0]                  window_count
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int W  = tlf_pkg::SUM_W;

	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] k);
		logic [CW:0] s;
		s = (CW+1)'(base) + (CW+1)'(k);
		if (s >= (CW+1)'(WINDOW_DEPTH)) s = s - (CW+1)'(WINDOW_DEPTH);
		return AW'(s);
	endfunction

	logic [63:0] sys_mem [WINDOW_DEPTH];
	logic [63:0] dev_mem [WINDOW_DEPTH];

	logic          kind_q;
	logic [63:0]   sb_q, sa_q, dev_q, last_dev_q, last_sys_q, rd_dev_q, rd_sys_q;
	logic [63:0]   dev0_q, sys0_q, x_q, y_q, mid, d0, s0, xn, yn;
	logic [AW-1:0] ptr_q, wr_addr, rd_addr;
	logic [CW-1:0] fill_q, k_q;
	logic [64:0]   mid_sum;
	logic          out_valid_q, drop_ok;
	logic [W-1:0]  sx_q, sxx_q, sy_q, sxy_q, d_q, na_q, nb_q, t_q, tmp_q;
	logic [W-1:0]  mul_a, mul_b, prod, div_num;
	logic [2:0]    mul_top;
	logic          mul_done, div_done;
	logic [63:0]   quo, slope_q, icpt_q;
	tlf_pkg::mul_op_t  mop_q;
	tlf_pkg::div_sel_t dsel_q;
	logic [2:0]    status_q;
	logic [63:0]   oslope_q, oicpt_q, ocdev_q, ocsys_q;
	logic [5:0]    ocnt_q;

	assign mid_sum = {1'b0, sb_q} + {1'b0, sa_q};
	assign mid     = mid_sum[64:1];
	assign wr_addr = slot(ptr_q, fill_q);
	assign rd_addr = slot(ptr_q, k_q);
	assign drop_ok = (fill_q != '0) && ((16'(fill_q) > 16'(max_queue_size))
		|| (16'(fill_q) >= 16'(WINDOW_DEPTH)));

	assign d0 = (k_q == '0) ? rd_dev_q : dev0_q;
	assign s0 = (k_q == '0) ? rd_sys_q : sys0_q;
	assign xn = rd_dev_q - d0;
	assign yn = rd_sys_q - s0;

	always_comb begin
		st.kind     = kind_q;
		st.rtt_over = (sa_q - sb_q) > 64'(max_rtt);
		st.fit_next = (16'(fill_q) >= 16'(tlf_pkg::MIN_FIT - 1));
		st.last_k   = ((CW+1)'(k_q) + (CW+1)'(1)) == (CW+1)'(fill_q);
		st.mul_done = mul_done;
		st.div_done = div_done;
		st.d_bad    = (d_q == '0) || d_q[W-1];
		st.out_free = !out_valid_q || out_ready;
	end

	always_comb begin
		mul_a   = W'(x_q);
		mul_b   = W'(x_q);
		mul_top = 3'd1;
		case (cmd.mul_op)
			tlf_pkg::MUL_XX: begin
				mul_b = W'(x_q);
			end
			tlf_pkg::MUL_XY: begin
				mul_b = W'($signed(y_q));
			end
			tlf_pkg::MUL_N_SXX: begin
				mul_a   = W'(fill_q);
				mul_b   = sxx_q;
				mul_top = 3'd0;
			end
			tlf_pkg::MUL_SX_SX: begin
				mul_a   = sx_q;
				mul_b   = sx_q;
				mul_top = 3'd7;
			end
			tlf_pkg::MUL_N_SXY: begin
				mul_a   = W'(fill_q);
				mul_b   = sxy_q;
				mul_top = 3'd0;
			end
			tlf_pkg::MUL_SX_SY: begin
				mul_a   = sx_q;
				mul_b   = sy_q;
				mul_top = 3'd7;
			end
			tlf_pkg::MUL_SXX_SY: begin
				mul_a   = sxx_q;
				mul_b   = sy_q;
				mul_top = 3'd7;
			end
			tlf_pkg::MUL_SXY_SX: begin
				mul_a   = sxy_q;
				mul_b   = sx_q;
				mul_top = 3'd7;
			end
			tlf_pkg::MUL_SYS0_D: begin
				mul_a = W'(sys0_q);
				mul_b = d_q;
			end
			tlf_pkg::MUL_NA_DEV0: begin
				mul_a = W'(dev0_q);
				mul_b = na_q;
			end
			default: begin
				mul_top = 3'd1;
			end
		endcase
	end

	assign div_num = (cmd.div_sel == tlf_pkg::DIV_SLOPE) ? {na_q[W-33:0], 32'b0} : t_q;

	tlf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.a_top  (mul_top),
		.prod   (prod),
		.done   (mul_done)
	);

	tlf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (d_q),
		.quo    (quo),
		.done   (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			sys_mem[wr_addr] <= mid;
			dev_mem[wr_addr] <= dev_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_k) begin
			rd_sys_q <= sys_mem[rd_addr];
			rd_dev_q <= dev_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			ptr_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_win) begin
				fill_q <= '0;
				ptr_q  <= '0;
			end else if (cmd.drop && drop_ok) begin
				ptr_q  <= (ptr_q == AW'(WINDOW_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
				fill_q <= fill_q - 1'b1;
			end else if (cmd.back && (fill_q != '0) && (dev_q < last_dev_q)) begin
				fill_q <= '0;
				ptr_q  <= '0;
			end else if (cmd.push) begin
				fill_q <= fill_q + 1'b1;
				k_q    <= '0;
			end
			if (mul_done && (mop_q == tlf_pkg::MUL_XY)) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			sb_q   <= sys_before;
			sa_q   <= sys_after;
			dev_q  <= dev_time;
		end
		if (cmd.push) begin
			last_dev_q <= dev_q;
			last_sys_q <= mid;
		end
		if (cmd.take_k) begin
			x_q <= xn;
			y_q <= yn;
			if (k_q == '0) begin
				dev0_q <= rd_dev_q;
				sys0_q <= rd_sys_q;
				sx_q   <= W'(xn);
				sy_q   <= W'($signed(yn));
				sxx_q  <= '0;
				sxy_q  <= '0;
			end else begin
				sx_q <= sx_q + W'(xn);
				sy_q <= sy_q + W'($signed(yn));
			end
		end
		if (cmd.mul_start) begin
			mop_q <= cmd.mul_op;
		end
		if (cmd.div_start) begin
			dsel_q <= cmd.div_sel;
		end
		if (mul_done) begin
			case (mop_q)
				tlf_pkg::MUL_XX:      sxx_q <= sxx_q + prod;
				tlf_pkg::MUL_XY:      sxy_q <= sxy_q + prod;
				tlf_pkg::MUL_N_SXX:   tmp_q <= prod;
				tlf_pkg::MUL_SX_SX:   d_q   <= tmp_q - prod;
				tlf_pkg::MUL_N_SXY:   tmp_q <= prod;
				tlf_pkg::MUL_SX_SY:   na_q  <= tmp_q - prod;
				tlf_pkg::MUL_SXX_SY:  tmp_q <= prod;
				tlf_pkg::MUL_SXY_SX:  nb_q  <= tmp_q - prod;
				tlf_pkg::MUL_SYS0_D:  t_q   <= prod + nb_q;
				tlf_pkg::MUL_NA_DEV0: t_q   <= t_q - prod;
				default:              tmp_q <= tmp_q;
			endcase
		end
		if (div_done) begin
			if (dsel_q == tlf_pkg::DIV_SLOPE) begin
				slope_q <= quo;
			end else begin
				icpt_q <= quo;
			end
		end
		if (cmd.emit) begin
			status_q <= cmd.code;
			oslope_q <= (cmd.code == tlf_pkg::ST_FITTED) ? slope_q : 64'd0;
			oicpt_q  <= (cmd.code == tlf_pkg::ST_FITTED) ? icpt_q : 64'd0;
			ocdev_q  <= (fill_q != '0) ? last_dev_q : 64'd0;
			ocsys_q  <= (fill_q != '0) ? last_sys_q : 64'd0;
			ocnt_q   <= 6'(fill_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign slope        = oslope_q;
	assign intercept    = oicpt_q;
	assign check_dev    = ocdev_q;
	assign check_sys    = ocsys_q;
	assign window_count = ocnt_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		16'(fill_q) <= 16'(WINDOW_DEPTH))
		else $error("window fill beyond depth");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		16'(ptr_q) < 16'(WINDOW_DEPTH))
		else $error("oldest pointer beyond depth");

	a_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_k |-> (k_q < fill_q))
		else $error("window walk reads past the newest entry");

endmodule

// ----- rtl/core/tlf_ctrl.sv -----
module tlf_ctrl #(
	parameter int MAX_REJECTS = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tlf_pkg::stat_t st,
	output tlf_pkg::cmd_t  cmd
);

	localparam int RJW = (MAX_REJECTS > 0) ? $clog2(MAX_REJECTS + 1) : 1;

	tlf_pkg::state_t   state_q, state_d;
	tlf_pkg::mul_op_t  op_q, op_d;
	tlf_pkg::div_sel_t sel_q, sel_d;
	tlf_pkg::status_t  code_q, code_d;
	logic [RJW-1:0]    rj_q, rj_d;
	logic              stopped_q, stopped_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tlf_pkg::S_IDLE;
			op_q      <= tlf_pkg::MUL_XX;
			sel_q     <= tlf_pkg::DIV_SLOPE;
			code_q    <= tlf_pkg::ST_CLEARED;
			rj_q      <= '0;
			stopped_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			op_q      <= op_d;
			sel_q     <= sel_d;
			code_q    <= code_d;
			rj_q      <= rj_d;
			stopped_q <= stopped_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		sel_d       = sel_q;
		code_d      = code_q;
		rj_d        = rj_q;
		stopped_d   = stopped_q;
		cmd         = '0;
		cmd.mul_op  = op_q;
		cmd.div_sel = sel_q;
		cmd.code    = code_q;
		in_ready    = 1'b0;
		case (state_q)
			tlf_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = tlf_pkg::S_CHECK;
				end
			end
			tlf_pkg::S_CHECK: begin
				if (st.kind) begin
					cmd.clear_win = 1'b1;
					rj_d      = '0;
					stopped_d = 1'b0;
					code_d    = tlf_pkg::ST_CLEARED;
					state_d   = tlf_pkg::S_FINISH;
				end else if (stopped_q) begin
					code_d  = tlf_pkg::ST_STOPPED;
					state_d = tlf_pkg::S_FINISH;
				end else if (st.rtt_over) begin
					if (rj_q >= RJW'(MAX_REJECTS)) begin
						stopped_d = 1'b1;
					end else begin
						rj_d = rj_q + 1'b1;
					end
					code_d  = tlf_pkg::ST_REJECT;
					state_d = tlf_pkg::S_FINISH;
				end else begin
					rj_d    = '0;
					state_d = tlf_pkg::S_DROP;
				end
			end
			tlf_pkg::S_DROP: begin
				cmd.drop = 1'b1;
				state_d  = tlf_pkg::S_BACK;
			end
			tlf_pkg::S_BACK: begin
				cmd.back = 1'b1;
				state_d  = tlf_pkg::S_PUSH;
			end
			tlf_pkg::S_PUSH: begin
				cmd.push = 1'b1;
				if (st.fit_next) begin
					state_d = tlf_pkg::S_WRD;
				end else begin
					code_d  = tlf_pkg::ST_COLLECT;
					state_d = tlf_pkg::S_FINISH;
				end
			end
			tlf_pkg::S_WRD: begin
				cmd.rd_k = 1'b1;
				state_d  = tlf_pkg::S_WTAKE;
			end
			tlf_pkg::S_WTAKE: begin
				cmd.take_k = 1'b1;
				op_d       = tlf_pkg::MUL_XX;
				state_d    = tlf_pkg::S_MUL_GO;
			end
			tlf_pkg::S_MUL_GO: begin
				cmd.mul_start = 1'b1;
				state_d       = tlf_pkg::S_MUL_WAIT;
			end
			tlf_pkg::S_MUL_WAIT: begin
				if (st.mul_done) begin
					case (op_q)
						tlf_pkg::MUL_XY: begin
							if (st.last_k) begin
								op_d    = tlf_pkg::MUL_N_SXX;
								state_d = tlf_pkg::S_MUL_GO;
							end else begin
								state_d = tlf_pkg::S_WRD;
							end
						end
						tlf_pkg::MUL_SX_SX: begin
							state_d = tlf_pkg::S_CHKD;
						end
						tlf_pkg::MUL_NA_DEV0: begin
							sel_d   = tlf_pkg::DIV_SLOPE;
							state_d = tlf_pkg::S_DIV_GO;
						end
						default: begin
							op_d    = tlf_pkg::mul_op_t'(op_q + 4'd1);
							state_d = tlf_pkg::S_MUL_GO;
						end
					endcase
				end
			end
			tlf_pkg::S_CHKD: begin
				if (st.d_bad) begin
					code_d  = tlf_pkg::ST_DEGEN;
					state_d = tlf_pkg::S_FINISH;
				end else begin
					op_d    = tlf_pkg::MUL_N_SXY;
					state_d = tlf_pkg::S_MUL_GO;
				end
			end
			tlf_pkg::S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = tlf_pkg::S_DIV_WAIT;
			end
			tlf_pkg::S_DIV_WAIT: begin
				if (st.div_done) begin
					if (sel_q == tlf_pkg::DIV_SLOPE) begin
						sel_d   = tlf_pkg::DIV_ICPT;
						state_d = tlf_pkg::S_DIV_GO;
					end else begin
						code_d  = tlf_pkg::ST_FITTED;
						state_d = tlf_pkg::S_FINISH;
					end
				end
			end
			tlf_pkg::S_FINISH: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = tlf_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tlf_pkg::S_IDLE;
			end
		endcase
	end

	a_stop_run: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> (rj_q == RJW'(MAX_REJECTS)))
		else $error("stop set without a full run of rejects");

	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		st.mul_done |-> (state_q == tlf_pkg::S_MUL_WAIT))
		else $error("multiplier finished outside its wait state");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> (state_q == tlf_pkg::S_DIV_WAIT))
		else $error("divider finished outside its wait state");

endmodule

// ----- rtl/core/timestamp_linear_fit.sv -----
// Channel   Dir  Handshake      Payload
// sample    in   valid/ready    kind, sys_before, sys_after, dev_time
// result    out  valid/ready    status, slope, intercept, check_dev, check_sys, window_count
// apb       in   psel/penable   max_queue_size at 0x0, max_rtt at 0x4
//
// One item is worked at a time; a finished result waits in the output register.
// Clear, stopped and rejected items and samples that leave fewer than four entries end
// without a fit. A fit over n entries costs two passes of the serial 32x32 multiplier
// for each entry, then eight wide products and two 256-step divisions follow. Reset is
// asynchronous and needs no clearing pass.
// A stalled result holds the block in its last state until the transfer.
module timestamp_linear_fit #(
	parameter int WINDOW_DEPTH = 32,
	parameter int MAX_REJECTS  = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	tlf_in_if.sink      sample,
	tlf_out_if.source   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [tlf_pkg::MQS_W-1:0] mqs_q;
	logic [tlf_pkg::RTT_W-1:0] rtt_q;
	logic                      in_ready;
	tlf_pkg::cmd_t             cmd;
	tlf_pkg::stat_t            st;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mqs_q <= tlf_pkg::MQS_W'(tlf_pkg::RESET_MQS);
			rtt_q <= tlf_pkg::RTT_W'(tlf_pkg::RESET_RTT);
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == tlf_pkg::REG_MAX_QUEUE) begin
				mqs_q <= pwdata[tlf_pkg::MQS_W-1:0];
			end else begin
				rtt_q <= pwdata[tlf_pkg::RTT_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == tlf_pkg::REG_MAX_RTT) ? 32'(rtt_q) : 32'(mqs_q);

	assign sample.ready = in_ready;

	tlf_ctrl #(
		.MAX_REJECTS (MAX_REJECTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	tlf_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.max_queue_size (mqs_q),
		.max_rtt        (rtt_q),
		.kind           (sample.kind),
		.sys_before     (sample.sys_before),
		.sys_after      (sample.sys_after),
		.dev_time       (sample.dev_time),
		.out_valid      (result.valid),
		.out_ready      (result.ready),
		.status         (result.status),
		.slope          (result.slope),
		.intercept      (result.intercept),
		.check_dev      (result.check_dev),
		.check_sys      (result.check_sys),
		.window_count   (result.window_count)
	);

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;

	localparam int DEPTH      = 32;
	localparam int REJECT_CAP = 5;
	localparam longint unsigned CYCLE_LIMIT = 64'd12_000_000;

	typedef struct packed {
		tlf_pkg::status_t   status;
		logic signed [63:0] slope;
		logic signed [63:0] intercept;
		logic [63:0]        check_dev;
		logic [63:0]        check_sys;
		logic [5:0]         window_count;
	} fit_result_t;

	typedef struct {
		logic             kind;
		logic [63:0]      sys_before;
		logic [63:0]      sys_after;
		logic [63:0]      dev_time;
		bit               typed;
		tlf_pkg::status_t status;
		logic [5:0]       count;
		logic [63:0]      cdev;
		logic [63:0]      csys;
	} row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	tlf_in_if  smp ();
	tlf_out_if res ();

	timestamp_linear_fit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (smp),
		.result  (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow of the block's window and control state.
	logic [63:0] win_sys [DEPTH];
	logic [63:0] win_dev [DEPTH];
	int unsigned win_head;
	int unsigned win_fill;
	int unsigned reject_cnt;
	bit          halted;
	int unsigned cfg_queue;
	logic [63:0] cfg_rtt;

	fit_result_t expected_fits[$];
	int unsigned errors;
	longint unsigned cycles;
	bit fast_send, fast_recv;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [63:0] div_sat(logic [255:0] num, logic [255:0] den);
		logic        neg;
		logic [255:0] mag, q;
		logic        high;
		logic [63:0] lim;
		neg  = num[255];
		mag  = neg ? (256'd0 - num) : num;
		q    = mag / den;
		high = |q[255:64];
		lim  = 64'h8000_0000_0000_0000;
		if (neg) begin
			if (high || q[63:0] > lim)
				return lim;
			return 64'd0 - q[63:0];
		end
		if (high || q[63:0] >= lim)
			return lim - 64'd1;
		return q[63:0];
	endfunction

	function automatic int unsigned slot_of(int unsigned k);
		return (win_head + k) % DEPTH;
	endfunction

	function automatic fit_result_t predict_fit(logic kind, logic [63:0] sb, logic [63:0] sa,
			logic [63:0] dev);
		fit_result_t r;
		logic [63:0] rtt, mid, dev0, sys0, yv;
		logic [255:0] sx, sxx, sy, sxy, x, y, n, d, na, nb, t;
		int unsigned s;
		r = '0;
		if (kind) begin
			win_fill   = 0;
			win_head   = 0;
			reject_cnt = 0;
			halted     = 0;
			r.status   = tlf_pkg::ST_CLEARED;
		end else if (halted) begin
			r.status = tlf_pkg::ST_STOPPED;
		end else begin
			rtt = sa - sb;
			mid = (sb >> 1) + (sa >> 1) + {63'd0, sb[0] & sa[0]};
			if (rtt > cfg_rtt) begin
				if (reject_cnt >= REJECT_CAP)
					halted = 1;
				else
					reject_cnt++;
				r.status = tlf_pkg::ST_REJECT;
			end else begin
				reject_cnt = 0;
				if (win_fill > 0 && (win_fill > cfg_queue || win_fill >= DEPTH)) begin
					win_head = (win_head + 1) % DEPTH;
					win_fill--;
				end
				if (win_fill > 0 && dev < win_dev[slot_of(win_fill - 1)]) begin
					win_fill = 0;
					win_head = 0;
				end
				win_sys[slot_of(win_fill)] = mid;
				win_dev[slot_of(win_fill)] = dev;
				win_fill++;
				if (win_fill < tlf_pkg::MIN_FIT) begin
					r.status = tlf_pkg::ST_COLLECT;
				end else begin
					dev0 = win_dev[win_head];
					sys0 = win_sys[win_head];
					sx = '0; sxx = '0; sy = '0; sxy = '0;
					for (int unsigned k = 0; k < win_fill; k++) begin
						s   = slot_of(k);
						x   = {192'd0, win_dev[s] - dev0};
						yv  = win_sys[s] - sys0;
						y   = {{192{yv[63]}}, yv};
						sx  = sx + x;
						sxx = sxx + x * x;
						sy  = sy + y;
						sxy = sxy + x * y;
					end
					n = 256'(win_fill);
					d = n * sxx - sx * sx;
					if (d == '0 || d[255]) begin
						r.status = tlf_pkg::ST_DEGEN;
					end else begin
						na = n * sxy - sx * sy;
						nb = sxx * sy - sxy * sx;
						r.slope = div_sat(na << 32, d);
						t = {192'd0, sys0} * d + nb - na * {192'd0, dev0};
						r.intercept = div_sat(t, d);
						r.status = tlf_pkg::ST_FITTED;
					end
				end
			end
		end
		if (win_fill > 0) begin
			r.check_dev = win_dev[slot_of(win_fill - 1)];
			r.check_sys = win_sys[slot_of(win_fill - 1)];
		end
		r.window_count = 6'(win_fill);
		return r;
	endfunction

	task automatic send_sample(logic kind, logic [63:0] sb, logic [63:0] sa, logic [63:0] dev,
			bit typed, fit_result_t typed_exp);
		int unsigned gap;
		fit_result_t pred;
		gap = fast_send ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			smp.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		smp.valid      = 1'b1;
		smp.kind       = kind;
		smp.sys_before = sb;
		smp.sys_after  = sa;
		smp.dev_time   = dev;
		do @(posedge clk); while (!smp.ready);
		pred = predict_fit(kind, sb, sa, dev);
		expected_fits.insert(expected_fits.size(), typed ? typed_exp : pred);
		@(negedge clk);
		smp.valid = 1'b0;
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = addr;
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic set_config(int unsigned queue_len, int unsigned rtt_max);
		while (expected_fits.size() != 0)
			@(negedge clk);
		smp.valid = 1'b0;
		apb_write({tlf_pkg::REG_MAX_QUEUE, 2'b00}, 32'(queue_len));
		apb_write({tlf_pkg::REG_MAX_RTT, 2'b00}, 32'(rtt_max));
		cfg_queue = queue_len & 5'h1F;
		cfg_rtt   = 64'(rtt_max & 20'hFFFFF);
	endtask

	// Receiver: stall a random number of cycles, then hold ready until a transfer.
	initial begin
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int unsigned k;
			@(negedge clk);
			k = fast_recv ? 0 : $urandom_range(0, 14);
			if (k > 0) begin
				res.ready = 1'b0;
				repeat (k) @(negedge clk);
			end
			res.ready = 1'b1;
			do @(posedge clk); while (!res.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			fit_result_t got, exp_r;
			got.status       = tlf_pkg::status_t'(res.status);
			got.slope        = res.slope;
			got.intercept    = res.intercept;
			got.check_dev    = res.check_dev;
			got.check_sys    = res.check_sys;
			got.window_count = res.window_count;
			if (expected_fits.size() == 0) begin
				errors++;
				$display("%0t: unexpected result status %0d count %0d", $realtime,
					got.status, got.window_count);
			end else begin
				exp_r = expected_fits[0];
				expected_fits.delete(0);
				if (got !== exp_r) begin
					errors++;
					$display("%0t: expected st %0d sl %h ic %h dev %h sys %h n %0d", $realtime,
						exp_r.status, exp_r.slope, exp_r.intercept, exp_r.check_dev,
						exp_r.check_sys, exp_r.window_count);
					$display("%0t: actual   st %0d sl %h ic %h dev %h sys %h n %0d", $realtime,
						got.status, got.slope, got.intercept, got.check_dev,
						got.check_sys, got.window_count);
				end
			end
		end
	end

	initial begin
		row_t rows[23];
		static int unsigned queue_lens[7] = '{4, 31, 0, 5, 2, 12, 4};
		static int unsigned rtt_maxes[7]  = '{20000, 1000000, 0, 500, 3000, 20000, 1000000};
		static int unsigned counts[7]     = '{300, 100, 80, 300, 150, 120, 150};
		logic [63:0] MAXV;
		logic [63:0] g_dev, g_sys, sb, sa, step;
		int unsigned reject_burst, pick, lim;
		fit_result_t te;

		MAXV = '1;
		cycles = 0; errors = 0; fast_send = 0; fast_recv = 0;
		arst_n = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		smp.valid = 0; smp.kind = 0; smp.sys_before = '0; smp.sys_after = '0;
		smp.dev_time = '0;
		win_head = 0; win_fill = 0; reject_cnt = 0; halted = 0;
		cfg_queue = tlf_pkg::RESET_MQS; cfg_rtt = tlf_pkg::RESET_RTT;

		// kind, sys_before, sys_after, dev, typed, status, count, check_dev, check_sys
		rows[0]  = '{1, 0, 0, 0, 1, tlf_pkg::ST_CLEARED, 0, 0, 0};
		rows[1]  = '{0, 1000, 999, 0, 1, tlf_pkg::ST_REJECT, 0, 0, 0};
		rows[2]  = '{0, 0, MAXV, 0, 1, tlf_pkg::ST_REJECT, 0, 0, 0};
		rows[3]  = '{0, 0, 20001, 7, 1, tlf_pkg::ST_REJECT, 0, 0, 0};
		rows[4]  = '{0, 5, 1000005, 7, 1, tlf_pkg::ST_REJECT, 0, 0, 0};
		rows[5]  = '{0, 5, 1000005, 7, 1, tlf_pkg::ST_REJECT, 0, 0, 0};
		rows[6]  = '{0, 5, 1000005, 7, 1, tlf_pkg::ST_REJECT, 0, 0, 0};
		rows[7]  = '{0, 0, 0, 0, 1, tlf_pkg::ST_STOPPED, 0, 0, 0};
		rows[8]  = '{1, 0, 0, 0, 1, tlf_pkg::ST_CLEARED, 0, 0, 0};
		rows[9]  = '{0, 0, 20000, 5, 1, tlf_pkg::ST_COLLECT, 1, 5, 10000};
		rows[10] = '{0, MAXV, MAXV, 5, 1, tlf_pkg::ST_COLLECT, 2, 5, MAXV};
		rows[11] = '{0, 100, 100, 5, 1, tlf_pkg::ST_COLLECT, 3, 5, 100};
		rows[12] = '{0, 100, 100, 5, 1, tlf_pkg::ST_DEGEN, 4, 5, 100};
		rows[13] = '{0, 50, 52, 3, 1, tlf_pkg::ST_COLLECT, 1, 3, 51};
		rows[14] = '{1, MAXV, 0, MAXV, 1, tlf_pkg::ST_CLEARED, 0, 0, 0};
		rows[15] = '{0, 1000, 1010, 0, 0, tlf_pkg::ST_FITTED, 0, 0, 0};
		rows[16] = '{0, 2000, 2004, 1000, 0, tlf_pkg::ST_FITTED, 0, 0, 0};
		rows[17] = '{0, 3010, 3030, 2000, 0, tlf_pkg::ST_FITTED, 0, 0, 0};
		rows[18] = '{0, 3990, 4000, 3000, 0, tlf_pkg::ST_FITTED, 0, 0, 0};
		rows[19] = '{0, 5100, 5120, 4000, 0, tlf_pkg::ST_FITTED, 0, 0, 0};
		rows[20] = '{0, 6000, 6000, MAXV, 0, tlf_pkg::ST_FITTED, 0, 0, 0};
		rows[21] = '{0, MAXV - 64'd5, MAXV, MAXV, 0, tlf_pkg::ST_FITTED, 0, 0, 0};
		rows[22] = '{1, 64'h5555_5555_5555_5555, 3, 9, 1, tlf_pkg::ST_CLEARED, 0, 0, 0};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			te = '0;
			te.status       = rows[i].status;
			te.window_count = rows[i].count;
			te.check_dev    = rows[i].cdev;
			te.check_sys    = rows[i].csys;
			send_sample(rows[i].kind, rows[i].sys_before, rows[i].sys_after,
				rows[i].dev_time, rows[i].typed, te);
		end

		te = '0;
		reject_burst = 0;
		foreach (counts[p]) begin
			set_config(queue_lens[p], rtt_maxes[p]);
			g_dev = {$urandom, $urandom};
			g_sys = {$urandom, $urandom};
			for (int unsigned i = 0; i < counts[p]; i++) begin
				if (i % 40 == 0) begin
					fast_send = ($urandom_range(0, 3) == 0);
					fast_recv = ($urandom_range(0, 3) == 0);
				end
				lim  = (cfg_rtt > 64'd5000) ? 5000 : int'(cfg_rtt);
				pick = $urandom_range(0, 99);
				if (reject_burst == 0 && pick < 2)
					reject_burst = $urandom_range(5, 8);
				if (reject_burst > 0) begin
					reject_burst--;
					sb = g_sys;
					sa = sb + cfg_rtt + 1 + $urandom_range(0, 1000);
					send_sample(0, sb, sa, g_dev, 0, te);
				end else if (pick < 6) begin
					send_sample(1, {$urandom, $urandom}, {$urandom, $urandom},
						{$urandom, $urandom}, 0, te);
				end else if (pick < 14) begin
					send_sample(0, {$urandom, $urandom}, {$urandom, $urandom},
						{$urandom, $urandom}, 0, te);
				end else if (pick < 17) begin
					sb = {$urandom, $urandom};
					send_sample(0, sb, sb - 64'($urandom_range(1, 100)), g_dev, 0, te);
				end else begin
					// Well-formed sample; now and then the device clock repeats or steps back.
					if (pick < 20)
						step = 64'd0 - 64'($urandom_range(1, 50000));
					else if (pick < 25)
						step = 0;
					else
						step = 64'($urandom_range(1, 200000));
					g_dev = g_dev + step;
					g_sys = g_sys + step + 64'($urandom_range(0, 200)) - 64'd100;
					sb = g_sys;
					sa = sb + 64'($urandom_range(0, lim));
					send_sample(0, sb, sa, g_dev, 0, te);
				end
			end
		end

		smp.valid = 1'b0;
		while (expected_fits.size() != 0)
			@(negedge clk);
		repeat (2500) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
